// ===== hw/rtl/bcq_pkg.sv =====
// Shared types, character codes and helpers for the bracket/comment/quote checker.
package bcq_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 4096;
  localparam int unsigned DEPTH_W         = 13;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // bracket kinds as stored on the stack
  localparam logic [1:0] KIND_PAREN = 2'd0;
  localparam logic [1:0] KIND_BRACK = 2'd1;
  localparam logic [1:0] KIND_BRACE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  typedef enum logic [7:0] {
    MODE_CODE    = 8'b0000_0001,
    MODE_SLASH   = 8'b0000_0010,
    MODE_COMMENT = 8'b0000_0100,
    MODE_STAR    = 8'b0000_1000,
    MODE_SQ      = 8'b0001_0000,
    MODE_SQ_ESC  = 8'b0010_0000,
    MODE_DQ      = 8'b0100_0000,
    MODE_DQ_ESC  = 8'b1000_0000
  } mode_e;

  // stack operation for one request
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [1:0] kind;
  } stack_cmd_t;

  // stack status as seen before the current request
  typedef struct packed {
    logic       empty;
    logic       full;
    logic [1:0] tos;
  } stack_stat_t;

  // one result item
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               mismatch;
    logic               overflow;
    logic               verdict;
    logic               ok;
  } result_t;

  function automatic logic [1:0] opener_kind(input logic [7:0] b);
    case (b)
      CH_LPAREN: opener_kind = KIND_PAREN;
      CH_LBRACK: opener_kind = KIND_BRACK;
      CH_LBRACE: opener_kind = KIND_BRACE;
      default:   opener_kind = KIND_NONE;
    endcase
  endfunction

  function automatic logic [1:0] closer_kind(input logic [7:0] b);
    case (b)
      CH_RPAREN: closer_kind = KIND_PAREN;
      CH_RBRACK: closer_kind = KIND_BRACK;
      CH_RBRACE: closer_kind = KIND_BRACE;
      default:   closer_kind = KIND_NONE;
    endcase
  endfunction

endpackage

// ===== hw/rtl/bracket_comment_quote_checker.sv =====
// Top level of the bracket/comment/quote checker: scanner, flags and output buffer.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------------
//  in      | in  | in_valid_i / in_ready_o | text_byte_i, end_of_text_i
//  out     | out | out_valid_o/out_ready_i | nesting_depth_o, mismatch_seen_o,
//          |     |                         | stack_overflow_o, verdict_valid_o, text_ok_o
//
// One byte per cycle while in_ready_o is high: each request updates mode, flags and stack in
// the cycle it is accepted; its result is registered in the output register or the skid.
// The top-of-stack register plus a forwarded read of the entry beneath it hide the
// registered read of the stack memory, so pops and pushes may follow back to back.
// A skid register behind the output register keeps one extra result; in_ready_o drops
// only when both are full. Reset clears mode, flags, pointer and buffers; the stack memory
// is not cleared (only entries below the pointer are ever used).
// A byte marked end_of_text returns the scanner to its reset state after its verdict.
module bracket_comment_quote_checker #(
  parameter int unsigned STACK_DEPTH = bcq_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  text_byte_i,
  input  logic                        end_of_text_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bcq_pkg::DEPTH_W-1:0] nesting_depth_o,
  output logic                        mismatch_seen_o,
  output logic                        stack_overflow_o,
  output logic                        verdict_valid_o,
  output logic                        text_ok_o
);
  import bcq_pkg::*;

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  logic        accept;
  mode_e       mode_q, mode_d;
  logic        mis_q, mis_d, ovf_q, ovf_d;
  logic        run_code, want_push, want_pop;
  logic [1:0]  ok_kind, ck_kind;
  stack_cmd_t  cmd;
  stack_stat_t stat;
  logic [SPW-1:0] sp_next;
  logic [31:0] sp_ext;
  result_t     res;

  // output register and skid
  logic        out_v_q, skid_v_q;
  result_t     out_q, skid_q;
  logic        fire;

  assign accept = in_valid_i && in_ready_o;
  assign fire   = out_v_q && out_ready_i;

  assign ok_kind = opener_kind(text_byte_i);
  assign ck_kind = closer_kind(text_byte_i);

  // ---- scanner: next mode and the bracket action of this byte
  always_comb begin
    mode_d    = mode_q;
    run_code  = 1'b0;
    want_push = 1'b0;
    want_pop  = 1'b0;
    case (mode_q)
      MODE_CODE: begin
        run_code = 1'b1;
      end
      MODE_SLASH: begin
        if (text_byte_i == CH_STAR) mode_d = MODE_COMMENT;
        else                        run_code = 1'b1;   // lone slash is dropped
      end
      MODE_COMMENT: begin
        mode_d = (text_byte_i == CH_STAR) ? MODE_STAR : MODE_COMMENT;
      end
      MODE_STAR: begin
        if (text_byte_i == CH_SLASH)     mode_d = MODE_CODE;
        else if (text_byte_i == CH_STAR) mode_d = MODE_STAR;
        else                             mode_d = MODE_COMMENT;
      end
      MODE_SQ: begin
        if (text_byte_i == CH_BSLASH)      mode_d = MODE_SQ_ESC;
        else if (text_byte_i == CH_SQUOTE) mode_d = MODE_CODE;
      end
      MODE_SQ_ESC: begin
        mode_d = MODE_SQ;
      end
      MODE_DQ: begin
        if (text_byte_i == CH_BSLASH)      mode_d = MODE_DQ_ESC;
        else if (text_byte_i == CH_DQUOTE) mode_d = MODE_CODE;
      end
      MODE_DQ_ESC: begin
        mode_d = MODE_DQ;
      end
      default: begin
        mode_d = MODE_CODE;
      end
    endcase

    if (run_code) begin
      mode_d = MODE_CODE;
      if (text_byte_i == CH_SQUOTE)      mode_d = MODE_SQ;
      else if (text_byte_i == CH_DQUOTE) mode_d = MODE_DQ;
      else if (text_byte_i == CH_SLASH)  mode_d = MODE_SLASH;
      else if (ok_kind != KIND_NONE)     want_push = 1'b1;
      else if (ck_kind != KIND_NONE)     want_pop = 1'b1;
    end
  end

  // ---- sticky flags; closer checked against the top-of-stack register
  always_comb begin
    mis_d = mis_q | (want_pop && (stat.empty || (stat.tos != ck_kind)));
    ovf_d = ovf_q | (want_push && stat.full);
  end

  assign cmd.push  = accept && want_push;
  assign cmd.pop   = accept && want_pop && !stat.empty;
  assign cmd.clear = accept && end_of_text_i;
  assign cmd.kind  = ok_kind;

  bcq_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .sp_next_o (sp_next)
  );

  // ---- result of this byte (state after the byte, before any end-of-text reset)
  assign sp_ext = 32'(sp_next);
  always_comb begin
    res.depth    = sp_ext[DEPTH_W-1:0];
    res.mismatch = mis_d;
    res.overflow = ovf_d;
    res.verdict  = end_of_text_i;
    res.ok       = end_of_text_i && (sp_next == '0) && !mis_d && !ovf_d &&
                   ((mode_d == MODE_CODE) || (mode_d == MODE_SLASH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
      mis_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      if (end_of_text_i) begin
        mode_q <= MODE_CODE;
        mis_q  <= 1'b0;
        ovf_q  <= 1'b0;
      end else begin
        mode_q <= mode_d;
        mis_q  <= mis_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // ---- output register with skid; input stalls only when both hold results
  assign in_ready_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (fire) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else if (!accept) begin
          out_v_q <= 1'b0;
        end
      end else if (accept) begin
        if (!out_v_q) out_v_q <= 1'b1;
        else          skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && skid_v_q) begin
      out_q <= skid_q;
    end else if (accept && (fire || !out_v_q)) begin
      out_q <= res;
    end
    if (accept && out_v_q && !fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_v_q;
  assign nesting_depth_o  = out_q.depth;
  assign mismatch_seen_o  = out_q.mismatch;
  assign stack_overflow_o = out_q.overflow;
  assign verdict_valid_o  = out_q.verdict;
  assign text_ok_o        = out_q.ok;

  // ---- assertions
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("skid holds a result while the output register is empty");

  a_ok_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_ok_o) |-> (verdict_valid_o && (nesting_depth_o == '0) &&
                                    !mismatch_seen_o && !stack_overflow_o))
    else $error("text_ok given without a clean verdict");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_text_i) |=> ((mode_q == MODE_CODE) && !mis_q && !ovf_q &&
                                   stat.empty))
    else $error("scanner not back in reset state after end of text");

  a_out_fire_or_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_o && !out_ready_i) |=> !in_ready_o)
    else $error("result accepted behind a stalled output but skid not filled");

endmodule

// ===== hw/rtl/bcq_stack.sv =====
// Bracket stack: top-of-stack register over a memory with a registered read.
module bcq_stack #(
  parameter int unsigned STACK_DEPTH = bcq_pkg::STACK_DEPTH_DEF,
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bcq_pkg::stack_cmd_t  cmd_i,
  output bcq_pkg::stack_stat_t stat_o,
  output logic [SPW-1:0]       sp_next_o
);
  import bcq_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // entries below the top; the top itself lives in tos_q
  logic [1:0]     mem [STACK_DEPTH];

  logic [SPW-1:0] sp_q, sp_d, sp_op;
  logic [1:0]     tos_q, tos_d;
  logic [1:0]     rdata_q;
  logic           fwd_q, fwd_d;
  logic [1:0]     fwd_val_q;
  logic [1:0]     below;
  logic           empty, full, push_ok, wr_en;
  logic [SPW-1:0] wr_sp, rd_sp;

  assign empty   = (sp_q == '0);
  assign full    = (sp_q == SPW'(STACK_DEPTH));
  assign push_ok = cmd_i.push && !full;
  assign wr_en   = push_ok && !empty;
  // entry just under the top: memory read issued last cycle, or the value written then
  assign below   = fwd_q ? fwd_val_q : rdata_q;

  always_comb begin
    sp_op = sp_q;
    tos_d = tos_q;
    if (push_ok) begin
      sp_op = sp_q + SPW'(1);
      tos_d = cmd_i.kind;
    end else if (cmd_i.pop && !empty) begin
      sp_op = sp_q - SPW'(1);
      tos_d = below;
    end
    sp_d  = cmd_i.clear ? '0 : sp_op;
    wr_sp = sp_q - SPW'(1);
    rd_sp = sp_op - SPW'(2);
    fwd_d = wr_en;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_sp[AW-1:0]] <= tos_q;
    end
    rdata_q   <= mem[rd_sp[AW-1:0]];
    fwd_val_q <= tos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      tos_q <= KIND_PAREN;
      fwd_q <= 1'b0;
    end else begin
      sp_q  <= sp_d;
      tos_q <= tos_d;
      fwd_q <= fwd_d;
    end
  end

  assign stat_o.empty = empty;
  assign stat_o.full  = full;
  assign stat_o.tos   = tos_q;
  assign sp_next_o    = sp_op;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for bracket_comment_quote_checker: directed, deep nesting, random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bcq_pkg::*;

  localparam int unsigned STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int unsigned DEEP_OPENS   = 300;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned TIMEOUT_NS   = 10_000_000;
  localparam result_t     NO_WANT      = '0;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           text_byte_i;
  logic                 end_of_text_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [DEPTH_W-1:0]   nesting_depth_o;
  logic                 mismatch_seen_o;
  logic                 stack_overflow_o;
  logic                 verdict_valid_o;
  logic                 text_ok_o;

  bracket_comment_quote_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .nesting_depth_o (nesting_depth_o),
    .mismatch_seen_o (mismatch_seen_o),
    .stack_overflow_o(stack_overflow_o),
    .verdict_valid_o (verdict_valid_o),
    .text_ok_o       (text_ok_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Scanner predictor: own copy of mode, bracket stack and sticky flags.
  // ---------------------------------------------------------------------------
  mode_e       scan_mode;
  logic [1:0]  bracket_mem [STACK_DEPTH];
  int unsigned open_count;
  logic        mis_flag;
  logic        ovf_flag;

  result_t     predicted_scans [$];   // one per accepted request, oldest first
  int unsigned bad_results;

  function automatic void reset_scanner();
    scan_mode  = MODE_CODE;
    open_count = 0;
    mis_flag   = 1'b0;
    ovf_flag   = 1'b0;
  endfunction

  // byte seen in code: quotes and slash change mode, brackets work the stack
  function automatic void scan_code(logic [7:0] b);
    logic [1:0] k;
    case (b)
      CH_SQUOTE: scan_mode = MODE_SQ;
      CH_DQUOTE: scan_mode = MODE_DQ;
      CH_SLASH:  scan_mode = MODE_SLASH;
      CH_LPAREN, CH_LBRACK, CH_LBRACE: begin
        k = (b == CH_LPAREN) ? KIND_PAREN : (b == CH_LBRACK) ? KIND_BRACK : KIND_BRACE;
        if (open_count < STACK_DEPTH) begin
          bracket_mem[open_count] = k;
          open_count++;
        end else begin
          ovf_flag = 1'b1;   // push on a full stack is dropped
        end
      end
      CH_RPAREN, CH_RBRACK, CH_RBRACE: begin
        k = (b == CH_RPAREN) ? KIND_PAREN : (b == CH_RBRACK) ? KIND_BRACK : KIND_BRACE;
        if (open_count == 0) begin
          mis_flag = 1'b1;   // closer with nothing open
        end else begin
          open_count--;
          if (bracket_mem[open_count] != k) mis_flag = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t scan_byte(logic [7:0] b, logic last);
    result_t r;
    case (scan_mode)
      MODE_CODE:  scan_code(b);
      MODE_SLASH: begin
        // slash without star: the slash is dropped, this byte is plain code
        if (b == CH_STAR) begin
          scan_mode = MODE_COMMENT;
        end else begin
          scan_mode = MODE_CODE;
          scan_code(b);
        end
      end
      MODE_COMMENT: scan_mode = (b == CH_STAR) ? MODE_STAR : MODE_COMMENT;
      MODE_STAR: begin
        if (b == CH_SLASH) scan_mode = MODE_CODE;
        else scan_mode = (b == CH_STAR) ? MODE_STAR : MODE_COMMENT;
      end
      MODE_SQ: begin
        if (b == CH_BSLASH) scan_mode = MODE_SQ_ESC;
        else if (b == CH_SQUOTE) scan_mode = MODE_CODE;
      end
      MODE_SQ_ESC: scan_mode = MODE_SQ;
      MODE_DQ: begin
        if (b == CH_BSLASH) scan_mode = MODE_DQ_ESC;
        else if (b == CH_DQUOTE) scan_mode = MODE_CODE;
      end
      default: scan_mode = MODE_DQ;
    endcase
    r.depth    = open_count[DEPTH_W-1:0];
    r.mismatch = mis_flag;
    r.overflow = ovf_flag;
    r.verdict  = last;
    // a trailing slash still counts as code
    r.ok       = last && open_count == 0 && !mis_flag && !ovf_flag &&
                 (scan_mode == MODE_CODE || scan_mode == MODE_SLASH);
    if (last) reset_scanner();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed text. Rows with typed=1 carry an expectation read straight off the
  // rules; the rest go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] chr;
    logic       last;
    bit         typed;
    result_t    want;
  } text_row_t;

  text_row_t directed_rows [26] = '{
    // closer right after reset, then top byte value ends the text
    '{CH_RPAREN, 1'b0, 1'b1, '{13'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'hFF,     1'b1, 1'b1, '{13'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
    // nesting, lone slash before a bracket, comment with stars, escaped quotes
    '{CH_LPAREN, 1'b0, 1'b0, NO_WANT},
    '{CH_LBRACE, 1'b0, 1'b0, NO_WANT},
    '{CH_SLASH,  1'b0, 1'b0, NO_WANT},
    '{CH_LBRACK, 1'b0, 1'b0, NO_WANT},
    '{CH_RBRACK, 1'b0, 1'b0, NO_WANT},
    '{CH_SLASH,  1'b0, 1'b0, NO_WANT},
    '{CH_STAR,   1'b0, 1'b0, NO_WANT},
    '{CH_LPAREN, 1'b0, 1'b0, NO_WANT},
    '{CH_STAR,   1'b0, 1'b0, NO_WANT},
    '{CH_STAR,   1'b0, 1'b0, NO_WANT},
    '{CH_SLASH,  1'b0, 1'b0, NO_WANT},
    '{CH_RBRACE, 1'b0, 1'b0, NO_WANT},
    '{CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_WANT},
    '{CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_WANT},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_RPAREN, 1'b0, 1'b0, NO_WANT},
    // ends right after a slash: still good
    '{CH_SLASH,  1'b1, 1'b1, '{13'd0, 1'b0, 1'b0, 1'b1, 1'b1}},
    // ends right after an escape inside a string: not good
    '{CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
    '{CH_BSLASH, 1'b1, 1'b1, '{13'd0, 1'b0, 1'b0, 1'b1, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // Random text builder
  // ---------------------------------------------------------------------------
  logic [7:0] text_buf [$];

  function automatic logic [7:0] open_char(logic [1:0] k);
    case (k)
      KIND_PAREN: return CH_LPAREN;
      KIND_BRACK: return CH_LBRACK;
      default:    return CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(logic [1:0] k);
    case (k)
      KIND_PAREN: return CH_RPAREN;
      KIND_BRACK: return CH_RBRACK;
      default:    return CH_RBRACE;
    endcase
  endfunction

  // body byte for comments and literals, biased toward the interesting ones
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 7))
      0:       return CH_STAR;
      1:       return CH_SLASH;
      2:       return open_char(2'($urandom_range(0, 2)));
      3:       return close_char(2'($urandom_range(0, 2)));
      4:       return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      5:       return CH_BSLASH;
      6:       return 8'(8'h61 + $urandom_range(0, 25));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well formed text with random content; the rest is broken on purpose.
  function automatic void compose_text();
    logic [1:0]  open_kinds [$];
    logic [7:0]  b;
    logic [7:0]  q;
    int unsigned goal;
    int unsigned n;
    bit          tidy;
    text_buf.delete();
    tidy = ($urandom_range(0, 9) < 7);
    goal = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 30);
    while (text_buf.size() < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          open_kinds.push_back(2'($urandom_range(0, 2)));
          text_buf.push_back(open_char(open_kinds[$]));
        end
        3, 4: begin
          if (open_kinds.size() != 0 && (tidy || $urandom_range(0, 3) != 0))
            text_buf.push_back(close_char(open_kinds.pop_back()));
          else if (!tidy)
            text_buf.push_back(close_char(2'($urandom_range(0, 2))));
        end
        5: begin
          text_buf.push_back(CH_SLASH);
          text_buf.push_back(CH_STAR);
          n = $urandom_range(0, 6);
          repeat (n) begin
            b = filler_byte();
            // keep an accidental close out of tidy comments
            if (tidy && b == CH_SLASH && text_buf[$] == CH_STAR) b = CH_STAR;
            text_buf.push_back(b);
          end
          if (tidy || $urandom_range(0, 3) != 0) begin
            text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
          end
        end
        6: begin
          q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
          text_buf.push_back(q);
          n = $urandom_range(0, 6);
          repeat (n) begin
            b = filler_byte();
            if (b == q || b == CH_BSLASH) begin
              // escape: any byte at all may follow
              text_buf.push_back(CH_BSLASH);
              text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
              text_buf.push_back(b);
            end
          end
          if (tidy || $urandom_range(0, 3) != 0) text_buf.push_back(q);
        end
        7: begin
          text_buf.push_back(CH_SLASH);
          text_buf.push_back(tidy ? 8'(8'h61 + $urandom_range(0, 25)) : filler_byte());
        end
        default: text_buf.push_back(tidy ? 8'(8'h20 + $urandom_range(0, 1) * 8'h41)
                                         : 8'($urandom_range(0, 255)));
      endcase
    end
    if (tidy) while (open_kinds.size() != 0) text_buf.push_back(close_char(open_kinds.pop_back()));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps between them.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned hold_asked;
  int unsigned hold_served;

  task automatic offer_byte(input logic [7:0] b, input logic last, input bit typed,
                            input result_t want);
    int unsigned gap;
    result_t     scanned;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    scanned = scan_byte(b, last);
    predicted_scans.push_back(typed ? want : scanned);
  endtask

  // stop sending until every outstanding result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_scans.size() != 0);
  endtask

  initial begin
    logic [1:0]  deep_kinds [$];
    int unsigned random_sent;
    bit          hold_done;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    text_byte_i   = 8'h00;
    end_of_text_i = 1'b0;
    bad_results   = 0;
    burst_left    = 0;
    hold_asked    = 0;
    random_sent   = 0;
    hold_done     = 1'b0;
    reset_scanner();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_byte(directed_rows[i].chr, directed_rows[i].last, directed_rows[i].typed,
                 directed_rows[i].want);
    drain_results();

    // Nest deeply with random openers, then unwind every one with its matching
    // closer so the stored entries are read back from the stack memory.
    repeat (DEEP_OPENS) begin
      deep_kinds.push_back(2'($urandom_range(0, 2)));
      offer_byte(open_char(deep_kinds[$]), 1'b0, 1'b0, NO_WANT);
    end
    for (int i = DEEP_OPENS - 1; i >= 0; i--)
      offer_byte(close_char(deep_kinds[i]), i == 0, 1'b0, NO_WANT);
    drain_results();

    while (random_sent < RANDOM_ITEMS) begin
      compose_text();
      foreach (text_buf[i])
        offer_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, NO_WANT);
      random_sent += text_buf.size();
      // one long receiver hold-off while requests keep coming
      if (!hold_done && random_sent > RANDOM_ITEMS / 3) begin
        hold_asked++;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    in_valid_i <= 1'b0;
    while (predicted_scans.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("bracket_comment_quote_checker verification clean");
    end else begin
      $display("bracket_comment_quote_checker verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: the ready pattern switches among random styles; a requested hold-off keeps
  // ready low until its counter, loaded from HOLD_CYCLES, runs out, so the block backs up.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned style_left;
  int unsigned ready_pct;

  initial begin
    out_ready_i = 1'b0;
    hold_served = 0;
    hold_left   = 0;
    style_left  = 0;
    ready_pct   = 100;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_ready_i <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      if (style_left == 0) begin
        style_left <= $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       ready_pct <= 100;
          1:       ready_pct <= 50;
          2:       ready_pct <= 20;
          default: ready_pct <= 85;
        endcase
      end else begin
        style_left <= style_left - 1;
      end
      out_ready_i <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{nesting_depth_o, mismatch_seen_o, stack_overflow_o, verdict_valid_o, text_ok_o};
      if (predicted_scans.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: result with nothing outstanding: depth %0d mis %b ovf %b vrd %b ok %b",
                   $realtime, got.depth, got.mismatch, got.overflow, got.verdict, got.ok);
      end else begin
        want = predicted_scans.pop_front();
        if (got.depth !== want.depth || got.mismatch !== want.mismatch ||
            got.overflow !== want.overflow || got.verdict !== want.verdict ||
            got.ok !== want.ok) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: mismatch exp depth %0d mis %b ovf %b vrd %b ok %b,",
                     $realtime, want.depth, want.mismatch, want.overflow, want.verdict,
                     want.ok,
                     " got depth %0d mis %b ovf %b vrd %b ok %b",
                     got.depth, got.mismatch, got.overflow, got.verdict, got.ok);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("bracket_comment_quote_checker verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bcq_pkg.sv
hw/rtl/bcq_stack.sv
hw/rtl/bracket_comment_quote_checker.sv
tb/testbench.sv
